[sv/gdo_pkg.sv]
// Shared types, constants and calendar helpers for the Gregorian date offset block.
package gdo_pkg;

    localparam int OFFSET_BITS_DEF = 18;
    localparam int YEAR_BITS       = 14;
    localparam int MONTH_BITS      = 4;
    localparam int DAY_BITS        = 5;
    localparam int CFG_ADDR_BITS   = 2;
    localparam int CFG_DATA_BITS   = 14;
    localparam int LEN_BITS        = 9;
    localparam int R400_BITS       = 9;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BASE_YEAR  = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BASE_MONTH = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_BASE_DAY   = 2'd2;

    localparam logic [YEAR_BITS-1:0]  BASE_YEAR_RST  = 14'd2022;
    localparam logic [MONTH_BITS-1:0] BASE_MONTH_RST = 4'd9;
    localparam logic [DAY_BITS-1:0]   BASE_DAY_RST   = 5'd29;

    // Largest in-range year; anything above it raises the range flag.
    localparam int YEAR_MAX   = 9999;
    // One past the largest base year the year register can hold.
    localparam int YEAR_LIMIT = 16384;

    localparam logic [MONTH_BITS-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_BITS-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_BITS-1:0] MONTH_DEC = 4'd12;

    localparam logic [LEN_BITS-1:0] DAYS_COMMON = 9'd365;
    localparam logic [LEN_BITS-1:0] DAYS_LEAP   = 9'd366;

    localparam logic [R400_BITS-1:0] R400_LAST = 9'd399;
    localparam logic [R400_BITS-1:0] R400_C100 = 9'd100;
    localparam logic [R400_BITS-1:0] R400_C200 = 9'd200;
    localparam logic [R400_BITS-1:0] R400_C300 = 9'd300;

    // The base year is reduced modulo 400 by restoring subtraction of 400 * 2^k.
    localparam int MOD_STEPS = 6;
    localparam logic [YEAR_BITS-1:0] MOD_DIV [MOD_STEPS] = '{
        14'd12800, 14'd6400, 14'd3200, 14'd1600, 14'd800, 14'd400
    };

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_INIT,
        S_BACK,
        S_FWDY,
        S_MON,
        S_DONE
    } gdo_state_t;

    typedef struct packed {
        logic [YEAR_BITS-1:0]  year;
        logic [MONTH_BITS-1:0] month;
        logic [DAY_BITS-1:0]   day;
        logic                  out_of_range;
    } gdo_result_t;

    // Leap test on the year taken modulo 400.
    function automatic logic is_leap(input logic [R400_BITS-1:0] r);
        return (r[1:0] == 2'b00) && (r != R400_C100) && (r != R400_C200) && (r != R400_C300);
    endfunction

    function automatic logic [R400_BITS-1:0] r400_inc(input logic [R400_BITS-1:0] r);
        return (r == R400_LAST) ? '0 : r + R400_BITS'(1);
    endfunction

    function automatic logic [R400_BITS-1:0] r400_dec(input logic [R400_BITS-1:0] r);
        return (r == '0) ? R400_LAST : r - R400_BITS'(1);
    endfunction

    // Length of a month; February grows by one in a leap year.
    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                      input logic leap);
        logic [DAY_BITS-1:0] len;
        unique case (m)
            4'd2:                     len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
            default:                  len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[sv/gdo_alu.sv]
// Shared adder/subtractor used by every arithmetic step of the date sequencer.
module gdo_alu #(
    parameter int AW = 20
) (
    input  logic [AW-1:0] a,
    input  logic [AW-1:0] b,
    input  logic          sub,
    output logic [AW-1:0] sum,
    output logic          neg
);

    assign sum = sub ? (a - b) : (a + b);
    assign neg = sum[AW-1];

endmodule

[sv/gdo_ctrl.sv]
// Sequencer that steps a date by whole years, then months; the days left give the day.
module gdo_ctrl #(
    parameter int OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [OFFSET_BITS-1:0]         in_offset,
    input  logic [gdo_pkg::YEAR_BITS-1:0]  base_year,
    input  logic [gdo_pkg::MONTH_BITS-1:0] base_month,
    input  logic [gdo_pkg::DAY_BITS-1:0]   base_day,
    output logic                           res_valid,
    input  logic                           res_ready,
    output gdo_pkg::gdo_result_t           res
);
    import gdo_pkg::*;

    // Day accumulator: holds the offset plus one month's worth of days, and
    // the base year while it is reduced modulo 400.
    localparam int AW = (OFFSET_BITS + 2 > 16) ? OFFSET_BITS + 2 : 16;
    // Signed year: base years up to 16383 plus the widest span of the offset.
    localparam int YW = $clog2(YEAR_LIMIT + (2 ** (OFFSET_BITS - 1)) / 365 + 2) + 1;

    gdo_state_t             state_reg, state_next;
    logic [AW-1:0]          t_reg, t_next;
    logic signed [YW-1:0]   y_reg, y_next;
    logic [R400_BITS-1:0]   r400_reg, r400_next;
    logic [MONTH_BITS-1:0]  m_reg, m_next;
    logic [2:0]             k_reg, k_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;

    logic [AW-1:0]         alu_a, alu_b, alu_sum;
    logic                  alu_sub, alu_neg;
    logic [R400_BITS-1:0]  r_inc, r_dec, r_mod;
    logic [MONTH_BITS-1:0] m_clamp;
    logic [DAY_BITS-1:0]   d_clamp;
    logic [LEN_BITS-1:0]   len_fwd, len_back;
    logic [DAY_BITS-1:0]   len_mon;
    logic                  year_high;

    gdo_alu #(.AW(AW)) u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .sum (alu_sum),
        .neg (alu_neg)
    );

    assign r_inc = r400_inc(r400_reg);
    assign r_dec = r400_dec(r400_reg);
    assign r_mod = t_reg[R400_BITS-1:0];

    // Base date clean-up, valid while the remainder sits in t_reg.
    always_comb begin
        m_clamp = ((base_month == '0) || (base_month > MONTH_DEC)) ? MONTH_JAN : base_month;
        d_clamp = ((base_day == '0) || (base_day > month_len(m_clamp, is_leap(r_mod))))
                  ? DAY_BITS'(1) : base_day;
    end

    // A forward year step from the first of January or February crosses February
    // of this year, else of the next year; a backward step, that of a year earlier.
    always_comb begin
        if (m_reg <= MONTH_FEB) begin
            len_fwd  = is_leap(r400_reg) ? DAYS_LEAP : DAYS_COMMON;
            len_back = is_leap(r_dec) ? DAYS_LEAP : DAYS_COMMON;
        end else begin
            len_fwd  = is_leap(r_inc) ? DAYS_LEAP : DAYS_COMMON;
            len_back = is_leap(r400_reg) ? DAYS_LEAP : DAYS_COMMON;
        end
        len_mon = month_len(m_reg, is_leap(r400_reg));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
        t_reg    <= t_next;
        y_reg    <= y_next;
        r400_reg <= r400_next;
        m_reg    <= m_next;
        k_reg    <= k_next;
        off_reg  <= off_next;
    end

    always_comb begin
        state_next = state_reg;
        t_next     = t_reg;
        y_next     = y_reg;
        r400_next  = r400_reg;
        m_next     = m_reg;
        k_next     = k_reg;
        off_next   = off_reg;
        alu_a      = t_reg;
        alu_b      = '0;
        alu_sub    = 1'b0;
        in_ready   = 1'b0;
        res_valid  = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    off_next   = in_offset;
                    t_next     = AW'(base_year);
                    y_next     = $signed(YW'(base_year));
                    k_next     = '0;
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                alu_b   = AW'(MOD_DIV[k_reg]);
                alu_sub = 1'b1;
                if (!alu_neg) begin
                    t_next = alu_sum;
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'(MOD_STEPS - 1)) begin
                    state_next = S_INIT;
                end
            end
            S_INIT: begin
                // Fold the day into the offset and work from the first of the month.
                r400_next  = r_mod;
                m_next     = m_clamp;
                alu_a      = {{(AW - OFFSET_BITS){off_reg[OFFSET_BITS-1]}}, off_reg};
                alu_b      = AW'(d_clamp - DAY_BITS'(1));
                t_next     = alu_sum;
                state_next = alu_neg ? S_BACK : S_FWDY;
            end
            S_BACK: begin
                alu_b      = AW'(len_back);
                t_next     = alu_sum;
                y_next     = y_reg - YW'(1);
                r400_next  = r_dec;
                if (!alu_neg) begin
                    state_next = S_FWDY;
                end
            end
            S_FWDY: begin
                alu_b   = AW'(len_fwd);
                alu_sub = 1'b1;
                if (!alu_neg) begin
                    t_next    = alu_sum;
                    y_next    = y_reg + YW'(1);
                    r400_next = r_inc;
                end else begin
                    state_next = S_MON;
                end
            end
            S_MON: begin
                alu_b   = AW'(len_mon);
                alu_sub = 1'b1;
                if (!alu_neg) begin
                    t_next = alu_sum;
                    if (m_reg == MONTH_DEC) begin
                        m_next    = MONTH_JAN;
                        y_next    = y_reg + YW'(1);
                        r400_next = r_inc;
                    end else begin
                        m_next = m_reg + MONTH_BITS'(1);
                    end
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign year_high        = y_reg > $signed(YW'(YEAR_MAX));
    assign res.year         = y_reg[YEAR_BITS-1:0];
    assign res.month        = m_reg;
    assign res.day          = t_reg[DAY_BITS-1:0] + DAY_BITS'(1);
    assign res.out_of_range = y_reg[YW-1] || year_high;

    a_mod_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MOD |-> k_reg < 3'(MOD_STEPS))
        else $error("modulo step counter ran past its last step");

    a_r400_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_BACK || state_reg == S_FWDY || state_reg == S_MON)
        |-> r400_reg <= R400_LAST)
        else $error("year modulo 400 left its range");

    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MON || state_reg == S_DONE)
        |-> (m_reg >= MONTH_JAN && m_reg <= MONTH_DEC))
        else $error("month register out of range");

    a_days_left: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DONE |-> (!t_reg[AW-1] && t_reg < AW'(31)))
        else $error("remaining days do not fit in the final month");

    a_back_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(state_reg) == S_FWDY && state_reg == S_FWDY) |-> !t_reg[AW-1])
        else $error("forward year stepping with a negative day count");

endmodule

[sv/gregorian_date_offset.sv]
// Top level: configuration registers, date sequencer and result register.
//
//  channel  | direction | beat payload
//  ---------+-----------+-----------------------------------------------
//  s_       | in        | tdata: day_offset (signed)
//  m_       | out       | tdata: target_year, target_month, target_day
//           |           | tuser: out_of_range
//  cfg_     | in        | write of base_year (0), base_month (1), base_day (2)
//
// A beat is worked in order: the base year is reduced modulo 400, the day is folded
// into the offset, then Y whole years are stepped (about |day_offset| / 365, at most 360
// for 18 offset bits) and then M months (at most 11). The year loop through the shared
// adder takes the largest share of the time a beat needs.
// Reset is synchronous on aresetn and restores the base date 2022-09-29.
// The result register frees the sequencer at once, so the next beat is taken
// while an earlier result still waits on m_tready.
module gregorian_date_offset #(
    parameter int OFFSET_BITS = gdo_pkg::OFFSET_BITS_DEF,
    localparam int S_TDATA_W  = ((OFFSET_BITS + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [gdo_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [gdo_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // From bit 0: day_offset, then zero padding.
    input  logic [S_TDATA_W-1:0]              s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // From bit 0: target_year[13:0], target_month[17:14], target_day[22:18], zero.
    output logic [23:0]                       m_tdata,
    // Bit 0: out_of_range.
    output logic                              m_tuser
);
    import gdo_pkg::*;

    logic [YEAR_BITS-1:0]  base_year_reg;
    logic [MONTH_BITS-1:0] base_month_reg;
    logic [DAY_BITS-1:0]   base_day_reg;

    logic        out_valid_reg;
    gdo_result_t out_reg;
    gdo_result_t res;
    logic        res_valid, res_ready;

    // Registers are written whenever the enable is high; unknown indexes drop.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_year_reg  <= BASE_YEAR_RST;
            base_month_reg <= BASE_MONTH_RST;
            base_day_reg   <= BASE_DAY_RST;
        end else if (cfg_we) begin
            if (cfg_addr == CFG_BASE_YEAR) begin
                base_year_reg <= cfg_wdata[YEAR_BITS-1:0];
            end
            if (cfg_addr == CFG_BASE_MONTH) begin
                base_month_reg <= cfg_wdata[MONTH_BITS-1:0];
            end
            if (cfg_addr == CFG_BASE_DAY) begin
                base_day_reg <= cfg_wdata[DAY_BITS-1:0];
            end
        end
    end

    gdo_ctrl #(.OFFSET_BITS(OFFSET_BITS)) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_offset  (s_tdata[OFFSET_BITS-1:0]),
        .base_year  (base_year_reg),
        .base_month (base_month_reg),
        .base_day   (base_day_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    // The result register takes a new result when it is empty or being drained.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg.day, out_reg.month, out_reg.year};
    assign m_tuser  = out_reg.out_of_range;

endmodule

[test/gdo_checker.sv]
// Checker that predicts each date the offset block must return and compares it with the result beats.
module gdo_checker #(
    parameter int OFFSET_W = gdo_pkg::OFFSET_BITS_DEF,
    parameter int TDATA_W  = ((OFFSET_W + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [gdo_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [gdo_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [TDATA_W-1:0]                s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [23:0]                       m_tdata,
    input  logic                              m_tuser,
    output int                                fail_count,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import gdo_pkg::*;

    // Years added before counting days so that every day number stays positive.
    localparam longint SHIFT_YEARS = 24000;
    localparam int MAX_LINES = 40;
    localparam int DAYS_IN_MONTH [13] = '{31, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [OFFSET_W-1:0] offset;
        gdo_result_t         date;
    } dated_offset_t;

    logic [YEAR_BITS-1:0]  base_year_q;
    logic [MONTH_BITS-1:0] base_month_q;
    logic [DAY_BITS-1:0]   base_day_q;
    dated_offset_t         expected_dates[$];

    function automatic bit leap_year_of(input longint y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Day number counted from a March-based calendar; the year must be at least 1.
    function automatic longint serial_day(input longint y, input longint m, input longint d);
        longint yy, era, yoe, mp, doy;
        yy  = (m <= 2) ? y - 1 : y;
        era = yy / 400;
        yoe = yy - era * 400;
        mp  = (m > 2) ? m - 3 : m + 9;
        doy = (153 * mp + 2) / 5 + d - 1;
        return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy;
    endfunction

    function automatic void calendar_of(input longint z, output longint y, output longint m,
                                        output longint d);
        longint era, doe, yoe, doy, mp;
        era = z / 146097;
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp  = (5 * doy + 2) / 153;
        m   = (mp < 10) ? mp + 3 : mp - 9;
        d   = doy - (153 * mp + 2) / 5 + 1;
        y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    endfunction

    function automatic gdo_result_t offset_date(input logic [OFFSET_W-1:0] off);
        longint m, d, mlen, z, ry, rm, rd, year;
        gdo_result_t r;
        m = base_month_q;
        if (m < 1 || m > 12) m = 1;
        mlen = DAYS_IN_MONTH[m] + ((m == 2 && leap_year_of(base_year_q)) ? 1 : 0);
        d = base_day_q;
        if (d < 1 || d > mlen) d = 1;
        z = serial_day(longint'(base_year_q) + SHIFT_YEARS, m, d) + longint'($signed(off));
        calendar_of(z, ry, rm, rd);
        year           = ry - SHIFT_YEARS;
        r.year         = year[YEAR_BITS-1:0];
        r.month        = rm[MONTH_BITS-1:0];
        r.day          = rd[DAY_BITS-1:0];
        r.out_of_range = (year < 0 || year > YEAR_MAX);
        return r;
    endfunction

    task automatic report_error(input string msg);
        if (fail_count < MAX_LINES) $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        dated_offset_t want;
        gdo_result_t   got;
        if (!aresetn) begin
            base_year_q  <= BASE_YEAR_RST;
            base_month_q <= BASE_MONTH_RST;
            base_day_q   <= BASE_DAY_RST;
            expected_dates.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_BASE_YEAR:  base_year_q  <= cfg_wdata[YEAR_BITS-1:0];
                    CFG_BASE_MONTH: base_month_q <= cfg_wdata[MONTH_BITS-1:0];
                    CFG_BASE_DAY:   base_day_q   <= cfg_wdata[DAY_BITS-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want.offset = s_tdata[OFFSET_W-1:0];
                want.date   = offset_date(s_tdata[OFFSET_W-1:0]);
                expected_dates.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.year         = m_tdata[YEAR_BITS-1:0];
                got.month        = m_tdata[YEAR_BITS +: MONTH_BITS];
                got.day          = m_tdata[YEAR_BITS + MONTH_BITS +: DAY_BITS];
                got.out_of_range = m_tuser;
                if (expected_dates.size() == 0) begin
                    report_error($sformatf("result beat %0d-%0d-%0d with no offset pending",
                                           got.year, got.month, got.day));
                end else begin
                    want = expected_dates.pop_front();
                    if (got.year !== want.date.year)
                        report_error($sformatf("offset %0d: year %0d, expected %0d",
                                     $signed(want.offset), got.year, want.date.year));
                    if (got.month !== want.date.month)
                        report_error($sformatf("offset %0d: month %0d, expected %0d",
                                     $signed(want.offset), got.month, want.date.month));
                    if (got.day !== want.date.day)
                        report_error($sformatf("offset %0d: day %0d, expected %0d",
                                     $signed(want.offset), got.day, want.date.day));
                    if (got.out_of_range !== want.date.out_of_range)
                        report_error($sformatf("offset %0d: range flag %b, expected %b",
                                     $signed(want.offset), got.out_of_range,
                                     want.date.out_of_range));
                end
            end
        end
        pending <= expected_dates.size();
    end

endmodule

[test/tb_gregorian_date_offset.sv]
// Testbench top for the Gregorian date offset block: clock, reset, stimulus and verdict.
module tb_gregorian_date_offset;
    timeunit 1ns;
    timeprecision 1ps;
    import gdo_pkg::*;

    localparam int OFFSET_W = OFFSET_BITS_DEF;
    localparam int TDATA_W  = ((OFFSET_W + 7) / 8) * 8;
    localparam int OFFSET_MAX = (1 << (OFFSET_W - 1)) - 1;

    // Register index that the block does not decode; writes to it must change nothing.
    localparam logic [CFG_ADDR_BITS-1:0] CFG_SPARE = 2'd3;

    // Hand-picked offsets from the reset base date: no move, single days, month
    // and year ends, whole years, whole centuries and the largest offset of either sign.
    localparam int DIRECTED [19] = '{
        0, 1, -1, 2, 93, 94, 365, 366, -365, -366, 36524, -36524,
        65536, -65536, 100000, -100000, OFFSET_MAX, -OFFSET_MAX, 883
    };

    // Fixed base dates. They cover a leap day, a leap day in a century year that is
    // not leap (clamped to day 1), the lowest and highest in-range years, a base year
    // above 9999 with a month past December, month and day of zero, a day past the
    // end of a 30-day month, the 30th of February in a leap year and month 13.
    localparam int N_FIXED = 9;
    localparam int PH_YEAR  [N_FIXED] = '{2000, 1900, 0, 9999, 16383, 2400, 2023, 2024, 1600};
    localparam int PH_MONTH [N_FIXED] = '{2,    2,    1, 12,   15,    0,    4,    2,    13};
    localparam int PH_DAY   [N_FIXED] = '{29,   29,   1, 31,   31,    0,    31,   30,   5};

    localparam int RESET_ITEMS  = 100;
    localparam int FIXED_ITEMS  = 70;
    localparam int N_RANDOM     = 6;
    localparam int RANDOM_ITEMS = 125;
    localparam int TOTAL_ITEMS  = 19 + RESET_ITEMS + N_FIXED * FIXED_ITEMS
                                  + N_RANDOM * RANDOM_ITEMS;
    // Items from here on are sent with both sides running flat out.
    localparam int CALM_FROM    = TOTAL_ITEMS - 250;
    // The receiver stops for a long stretch once this many beats have gone in.
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 3000;
    // Extra wait at the end, after every result has been taken.
    localparam int DRAIN_CYCLES = 400;
    localparam int LIMIT        = 3_000_000;

    logic                     aclk      = 1'b0;
    logic                     aresetn   = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr  = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_tvalid  = 1'b0;
    logic                     s_tready;
    // From bit 0: day_offset, then zero padding.
    logic [TDATA_W-1:0]       s_tdata   = '0;
    logic                     m_tvalid;
    logic                     m_tready  = 1'b0;
    // From bit 0: target_year[13:0], target_month[17:14], target_day[22:18], zero.
    logic [23:0]              m_tdata;
    // Bit 0: out_of_range.
    logic                     m_tuser;

    int fail_count;
    int pending;
    int sent_count = 0;
    int cycle_count = 0;

    always #5 aclk = ~aclk;

    gregorian_date_offset #(.OFFSET_BITS(OFFSET_W)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    gdo_checker #(.OFFSET_W(OFFSET_W), .TDATA_W(TDATA_W)) checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    // Most offsets are small, so that the year loop stays short and the run fast;
    // the rest reach into the full signed range or land on calendar boundaries.
    function automatic logic [OFFSET_W-1:0] pick_offset();
        int sel, v;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            v = int'($urandom_range(0, 4000)) - 2000;
        else if (sel < 7)
            v = int'($urandom_range(0, 80000)) - 40000;
        else if (sel < 9)
            v = int'($urandom_range(0, 2 * OFFSET_MAX)) - OFFSET_MAX;
        else begin
            case ($urandom_range(0, 5))
                0:       v = OFFSET_MAX;
                1:       v = 1461;
                2:       v = 36525;
                3:       v = 59;
                4:       v = 60;
                default: v = 0;
            endcase
            if ($urandom_range(0, 1) == 1) v = -v;
        end
        return OFFSET_W'(v);
    endfunction

    // The sender pauses between items except in the calm stretches and the tail.
    function automatic bit sender_may_idle();
        return (sent_count < CALM_FROM) && ((sent_count / 120) % 4 != 3);
    endfunction

    // Offers one offset beat and returns once it has been taken. The valid is left
    // high so that back-to-back beats need no second assignment in the same step.
    task automatic send_offset(input logic [OFFSET_W-1:0] off);
        if (sender_may_idle() && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(off);
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_count++;
    endtask

    // Drops the valid and waits until every result of the beats sent so far has
    // been taken. The first edge lets the checker count the last beat.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    // Loads a new base date while the block is idle and then streams offsets against
    // it. With scramble set, the unused upper bits of the narrow registers carry
    // random junk and the undecoded index gets a write as well.
    task automatic run_phase(input int y, input int m, input int d, input int n,
                             input bit scramble);
        logic [CFG_DATA_BITS-1:0] junk;
        drain_results();
        junk = scramble ? CFG_DATA_BITS'($urandom) : '0;
        write_reg(CFG_BASE_YEAR, CFG_DATA_BITS'(y));
        write_reg(CFG_BASE_MONTH, {junk[CFG_DATA_BITS-1:MONTH_BITS], MONTH_BITS'(m)});
        write_reg(CFG_BASE_DAY, {junk[CFG_DATA_BITS-1:DAY_BITS], DAY_BITS'(d)});
        if (scramble) write_reg(CFG_SPARE, CFG_DATA_BITS'($urandom));
        cfg_we <= 1'b0;
        repeat (n) send_offset(pick_offset());
    endtask

    // The run ends here if results stop coming.
    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Result side: short random stalls, quiet stretches, and one long hold-off that
    // lets the block fill up and push back on the sender.
    initial begin : result_sink
        int ticks;
        int n;
        bit held;
        ticks = 0;
        held  = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (!held && sent_count >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                ticks += HOLD_CYCLES;
            end else if (sent_count < CALM_FROM && (ticks / 500) % 4 != 3
                         && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 5);
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
                ticks += n;
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
                ticks++;
            end
        end
    end

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed offsets against the reset base date, then random ones.
        foreach (DIRECTED[i]) send_offset(OFFSET_W'(DIRECTED[i]));
        repeat (RESET_ITEMS) send_offset(pick_offset());

        for (int p = 0; p < N_FIXED; p++)
            run_phase(PH_YEAR[p], PH_MONTH[p], PH_DAY[p], FIXED_ITEMS, 1'b0);

        // Random base dates; the first may use any year the register holds, the
        // others stay in range. Month and day include invalid values.
        for (int p = 0; p < N_RANDOM; p++)
            run_phase($urandom_range(0, (p == 0) ? YEAR_LIMIT - 1 : YEAR_MAX),
                      $urandom_range(0, 15), $urandom_range(0, 31), RANDOM_ITEMS, 1'b1);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
sv/gdo_pkg.sv
sv/gdo_alu.sv
sv/gdo_ctrl.sv
sv/gregorian_date_offset.sv
test/gdo_checker.sv
test/tb_gregorian_date_offset.sv
